### hdl/rrc_pkg.sv
// Shared types and constants for the rectangle raster canvas.
`default_nettype none

package rrc_pkg;

   // Frame store geometry.
   localparam int MAX_SIDE   = 256;
   localparam int SIDE_BITS  = 8;
   localparam int ADDR_BITS  = 2 * SIDE_BITS;
   localparam int DIM_BITS   = SIDE_BITS + 1;

   // Fixed-point coordinates: 24-bit inputs, widened for sums and margins.
   localparam int FRAC_BITS  = 8;
   localparam int IN_BITS    = 24;
   localparam int COORD_BITS = IN_BITS + 2;

   // Request kinds.
   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_DRAW   = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // Result status codes.
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_BADRECT = 2'd1;
   localparam logic [1:0] STAT_OUTSIDE = 2'd2;

   // Shape codes.
   localparam logic [7:0] CODE_FILLED  = 8'h52;
   localparam logic [7:0] CODE_OUTLINE = 8'h72;

   // Configuration register indexes.
   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_BG     = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan;
      logic rd;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] kind;
      logic       invalid;
      logic       empty;
      logic       outside;
      logic       scan_last;
   } sts_type;

endpackage

`default_nettype wire

### hdl/rrc_ctrl.sv
// Request sequencer of the rectangle raster canvas.
`default_nettype none

module rrc_ctrl
   import rrc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  sts_type      sts,
   output logic         busy,
   output logic         rsp_valid,
   output cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            unique case (sts.kind)
               REQ_CLEAR: state_in = sts.empty ? ST_RESP : ST_SCAN;
               REQ_DRAW:  state_in = (sts.invalid || sts.empty) ? ST_RESP : ST_SCAN;
               REQ_READ:  state_in = sts.outside ? ST_RESP : ST_READ;
               default:   state_in = ST_RESP;
            endcase
         end
         ST_SCAN: begin
            if (sts.scan_last) state_in = ST_RESP;
         end
         ST_READ:  state_in = ST_RESP;
         ST_RESP:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands and handshake outputs.
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign cmd.load  = (state_ff == ST_IDLE) && start;
   assign cmd.scan  = (state_ff == ST_SCAN);
   assign cmd.rd    = (state_ff == ST_READ);

   // An accepted request makes the block busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // A result is shown for a single cycle and is followed by idle.
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe lasted more than one cycle");

   // A result never appears without work having been in progress.
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a request in progress");

endmodule

`default_nettype wire

### hdl/rrc_dpath.sv
// Datapath of the rectangle raster canvas: registers, scan counters, coverage test, frame store.
`default_nettype none

module rrc_dpath
   import rrc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_en,
   input  wire logic [1:0]            csr_index,
   input  wire logic [DIM_BITS-1:0]   csr_data,
   input  wire logic [1:0]            req_type,
   input  wire logic [IN_BITS-1:0]    req_rect_left,
   input  wire logic [IN_BITS-1:0]    req_rect_top,
   input  wire logic [IN_BITS-1:0]    req_rect_width,
   input  wire logic [IN_BITS-1:0]    req_rect_height,
   input  wire logic [7:0]            req_shape_code,
   input  wire logic [7:0]            req_fill_char,
   input  wire logic [SIDE_BITS-1:0]  req_read_col,
   input  wire logic [SIDE_BITS-1:0]  req_read_row,
   input  cmd_type                    cmd,
   output sts_type                    sts,
   output logic [1:0]                 rsp_status,
   output logic [7:0]                 rsp_pixel
);

   localparam logic signed [COORD_BITS-1:0] ONE = COORD_BITS'(1 << FRAC_BITS);
   localparam logic [DIM_BITS-1:0] SIDE_MAX = DIM_BITS'(MAX_SIDE);

   // Configuration registers.
   logic [DIM_BITS-1:0] cfg_width_ff;
   logic [DIM_BITS-1:0] cfg_height_ff;
   logic [7:0]          cfg_bg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= DIM_BITS'(1);
         cfg_height_ff <= DIM_BITS'(1);
         cfg_bg_ff     <= 8'd32;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_WIDTH:  cfg_width_ff  <= csr_data;
            CSR_HEIGHT: cfg_height_ff <= csr_data;
            CSR_BG:     cfg_bg_ff     <= csr_data[7:0];
            default:    ;
         endcase
      end
   end

   // Active canvas size, saturated to the frame store side.
   logic [DIM_BITS-1:0] act_w;
   logic [DIM_BITS-1:0] act_h;
   assign act_w = (cfg_width_ff  > SIDE_MAX) ? SIDE_MAX : cfg_width_ff;
   assign act_h = (cfg_height_ff > SIDE_MAX) ? SIDE_MAX : cfg_height_ff;

   // Sign-extended request coordinates.
   logic signed [COORD_BITS-1:0] left_in, top_in, wid_in, hgt_in;
   assign left_in = signed'({{2{req_rect_left[IN_BITS-1]}}, req_rect_left});
   assign top_in  = signed'({{2{req_rect_top[IN_BITS-1]}}, req_rect_top});
   assign wid_in  = signed'({{2{req_rect_width[IN_BITS-1]}}, req_rect_width});
   assign hgt_in  = signed'({{2{req_rect_height[IN_BITS-1]}}, req_rect_height});

   logic invalid_in;
   assign invalid_in = req_rect_width[IN_BITS-1] || (req_rect_width == '0) ||
                       req_rect_height[IN_BITS-1] || (req_rect_height == '0) ||
                       ((req_shape_code != CODE_FILLED) &&
                        (req_shape_code != CODE_OUTLINE));

   // Request registers, loaded when a request transfer is taken.
   logic [1:0]                   kind_ff;
   logic signed [COORD_BITS-1:0] left_ff, right_ff, top_ff, bot_ff;
   logic signed [COORD_BITS-1:0] lin_ff, tin_ff, rin_ff, bin_ff;
   logic                         invalid_ff;
   logic                         filled_ff;
   logic [7:0]                   fill_ff;
   logic [SIDE_BITS-1:0]         rcol_ff, rrow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= REQ_UNUSED;
         invalid_ff <= 1'b0;
      end else if (cmd.load) begin
         kind_ff    <= req_type;
         invalid_ff <= invalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         left_ff   <= left_in;
         top_ff    <= top_in;
         right_ff  <= left_in + wid_in;
         bot_ff    <= top_in + hgt_in;
         lin_ff    <= left_in + ONE;
         tin_ff    <= top_in + ONE;
         filled_ff <= (req_shape_code == CODE_FILLED);
         fill_ff   <= req_fill_char;
         rcol_ff   <= req_read_col;
         rrow_ff   <= req_read_row;
      end
      // Inner right and bottom bounds settle during the check cycle.
      rin_ff <= right_ff - ONE;
      bin_ff <= bot_ff - ONE;
   end

   // Scan counters.
   logic [SIDE_BITS-1:0] col_ff, row_ff, col_in, row_in;
   logic                 col_last, row_last;
   assign col_last = ({1'b0, col_ff} == (act_w - DIM_BITS'(1)));
   assign row_last = ({1'b0, row_ff} == (act_h - DIM_BITS'(1)));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.load) begin
         col_in = '0;
         row_in = '0;
      end else if (cmd.scan) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + SIDE_BITS'(1);
         end else begin
            col_in = col_ff + SIDE_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Coverage test of the current pixel against the rectangle.
   logic signed [COORD_BITS-1:0] px, py;
   logic                         in_rect, near_edge, covered;
   assign px = signed'({{(COORD_BITS-SIDE_BITS-FRAC_BITS){1'b0}}, col_ff,
                        {FRAC_BITS{1'b0}}});
   assign py = signed'({{(COORD_BITS-SIDE_BITS-FRAC_BITS){1'b0}}, row_ff,
                        {FRAC_BITS{1'b0}}});
   assign in_rect   = (px >= left_ff) && (px <= right_ff) &&
                      (py >= top_ff) && (py <= bot_ff);
   assign near_edge = (px < lin_ff) || (py < tin_ff) ||
                      (px > rin_ff) || (py > bin_ff);
   assign covered   = in_rect && (near_edge || filled_ff);

   // Frame store: one write port for the scan, one registered read port.
   logic [7:0]           store [0:MAX_SIDE*MAX_SIDE-1];
   logic                 wr_en;
   logic [7:0]           wr_data;
   logic [ADDR_BITS-1:0] wr_addr, rd_addr;
   logic [7:0]           rd_data_ff;

   assign wr_en   = cmd.scan && ((kind_ff == REQ_CLEAR) || covered);
   assign wr_data = (kind_ff == REQ_CLEAR) ? cfg_bg_ff : fill_ff;
   assign wr_addr = {row_ff, col_ff};
   assign rd_addr = {rrow_ff, rcol_ff};

   always_ff @(posedge clock) begin
      if (wr_en) store[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) rd_data_ff <= store[rd_addr];
   end

   // Status toward the controller.
   logic outside;
   assign outside = ({1'b0, rcol_ff} >= act_w) || ({1'b0, rrow_ff} >= act_h);

   assign sts.kind      = kind_ff;
   assign sts.invalid   = invalid_ff;
   assign sts.empty     = (act_w == '0) || (act_h == '0);
   assign sts.outside   = outside;
   assign sts.scan_last = col_last && row_last;

   // Result status holds from the check cycle on; the pixel is the registered store read.
   always_comb begin
      rsp_status = STAT_OK;
      rsp_pixel  = 8'd0;
      if ((kind_ff == REQ_DRAW) && invalid_ff) begin
         rsp_status = STAT_BADRECT;
      end else if (kind_ff == REQ_READ) begin
         if (outside) rsp_status = STAT_OUTSIDE;
         else         rsp_pixel  = rd_data_ff;
      end
   end

endmodule

`default_nettype wire

### hdl/rectangle_raster_canvas.sv
// Top level of the rectangle raster canvas: sequencer plus datapath.
//
//   channel   ports                                  transfer when
//   request   start, busy, req_*                     start high and busy low
//   result    rsp_valid, rsp_status, rsp_pixel       rsp_valid high (one cycle)
//   config    csr_write_en, csr_index, csr_data      csr_write_en high
//
// A clear or a valid draw passes from the transfer through the check state, the
// scan state, which steps through every canvas pixel over the single frame store
// write port, and the result state. A read passes through check, registered store
// read and result; a rejected or empty request and the unused kind go from check
// straight to result. Reset is synchronous and clears the sequencer and the
// configuration; the frame store is undefined until cleared.
// The receiver cannot stall: each result is taken in the cycle it is shown.
`default_nettype none

module rectangle_raster_canvas
   import rrc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_en,
   input  wire logic [1:0]            csr_index,
   input  wire logic [DIM_BITS-1:0]   csr_data,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [1:0]            req_type,
   input  wire logic [IN_BITS-1:0]    req_rect_left,
   input  wire logic [IN_BITS-1:0]    req_rect_top,
   input  wire logic [IN_BITS-1:0]    req_rect_width,
   input  wire logic [IN_BITS-1:0]    req_rect_height,
   input  wire logic [7:0]            req_shape_code,
   input  wire logic [7:0]            req_fill_char,
   input  wire logic [SIDE_BITS-1:0]  req_read_col,
   input  wire logic [SIDE_BITS-1:0]  req_read_row,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_status,
   output logic [7:0]                 rsp_pixel
);

   cmd_type cmd;
   sts_type sts;

   // Sequencer.
   rrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // Datapath and frame store.
   rrc_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_type        (req_type),
      .req_rect_left   (req_rect_left),
      .req_rect_top    (req_rect_top),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_shape_code  (req_shape_code),
      .req_fill_char   (req_fill_char),
      .req_read_col    (req_read_col),
      .req_read_row    (req_read_row),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_status      (rsp_status),
      .rsp_pixel       (rsp_pixel)
   );

endmodule

`default_nettype wire
